@@ rtl/core/puv_pkg.sv @@
// Shared constants for the printable UTF-8 validator.
package puv_pkg;

	// error kind codes
	localparam logic [2:0] KIND_NONE     = 3'd0;
	localparam logic [2:0] KIND_CONTROL  = 3'd1;
	localparam logic [2:0] KIND_BAD_LEAD = 3'd2;
	localparam logic [2:0] KIND_BAD_CONT = 3'd3;
	localparam logic [2:0] KIND_TRUNC    = 3'd4;

	// byte classes
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] DEL_CHAR   = 8'h7f;
	localparam logic [7:0] CONT_MASK  = 8'hc0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'he0;
	localparam logic [7:0] LEAD2_CODE = 8'hc0;
	localparam logic [7:0] LEAD3_MASK = 8'hf0;
	localparam logic [7:0] LEAD3_CODE = 8'he0;
	localparam logic [7:0] LEAD4_MASK = 8'hf8;
	localparam logic [7:0] LEAD4_CODE = 8'hf0;

	// result beat layout
	localparam int RESULT_W = 12;
	localparam int M_DATA_W = 16;

endpackage

@@ rtl/core/printable_utf8_validator_core.sv @@
// The result beat is registered and appears on m_axis in the cycle after the last byte is accepted.
// One byte per cycle unless a held result stalls; state updates as each byte is taken.
// The output register frees in the cycle its beat is taken, so bytes keep flowing.
// Reset: arst_n clears the string state and the output valid asynchronously.
// Positions saturate at min(MAX_LEN-1, 255); state returns to reset after each string.
module printable_utf8_validator_core #(
	parameter int MAX_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [0] is_valid, [3:1] error_kind, [11:4] error_pos
);

	localparam int POS_MAX_I = (MAX_LEN - 1 < 255) ? MAX_LEN - 1 : 255;
	localparam logic [7:0] POS_MAX = POS_MAX_I[7:0];

	// string state
	logic [7:0] idx_q;
	logic [1:0] cont_q;
	logic [7:0] seq_start_q;
	logic [2:0] kind_q;
	logic [7:0] epos_q;
	logic       tent_q;

	// next state
	logic [7:0] idx_d;
	logic [1:0] cont_d;
	logic [7:0] seq_start_d;
	logic [2:0] kind_d;
	logic [7:0] epos_d;
	logic       tent_d;

	// result beat
	logic [puv_pkg::RESULT_W-1:0] res_d;
	logic [puv_pkg::RESULT_W-1:0] res_q;
	logic                         out_valid_q;

	logic accept;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// check one byte against the current sequence state
	always_comb begin
		logic [7:0] b;
		logic       final_err;
		logic [1:0] extra;
		logic [2:0] k;
		logic [7:0] p;
		b           = s_axis_tdata;
		final_err   = (kind_q != puv_pkg::KIND_NONE) && !tent_q;
		extra       = 2'd0;
		cont_d      = cont_q;
		seq_start_d = seq_start_q;
		kind_d      = kind_q;
		epos_d      = epos_q;
		tent_d      = tent_q;
		if ((b & puv_pkg::LEAD2_MASK) == puv_pkg::LEAD2_CODE) begin
			extra = 2'd1;
		end else if ((b & puv_pkg::LEAD3_MASK) == puv_pkg::LEAD3_CODE) begin
			extra = 2'd2;
		end else if ((b & puv_pkg::LEAD4_MASK) == puv_pkg::LEAD4_CODE) begin
			extra = 2'd3;
		end
		if (!final_err) begin
			if (cont_q != 2'd0) begin
				if ((b & puv_pkg::CONT_MASK) != puv_pkg::CONT_CODE
						&& kind_q == puv_pkg::KIND_NONE) begin
					kind_d = puv_pkg::KIND_BAD_CONT;
					epos_d = idx_q;
					tent_d = 1'b1;
				end
				cont_d = cont_q - 2'd1;
				if (cont_q == 2'd1) begin
					tent_d = 1'b0;
				end
			end else if (b < puv_pkg::CTRL_LIMIT || b == puv_pkg::DEL_CHAR) begin
				kind_d = puv_pkg::KIND_CONTROL;
				epos_d = idx_q;
				tent_d = 1'b0;
			end else if (b >= puv_pkg::CONT_CODE) begin
				if (extra == 2'd0) begin
					kind_d = puv_pkg::KIND_BAD_LEAD;
					epos_d = idx_q;
					tent_d = 1'b0;
				end else begin
					seq_start_d = idx_q;
					cont_d      = extra;
				end
			end
		end
		idx_d = (idx_q < POS_MAX) ? idx_q + 8'd1 : idx_q;

		// end of string: report truncation unless an error is already final
		k = kind_d;
		p = epos_d;
		if (!((kind_d != puv_pkg::KIND_NONE) && !tent_d) && cont_d != 2'd0) begin
			k = puv_pkg::KIND_TRUNC;
			p = seq_start_d;
		end
		res_d = {p, k, (k == puv_pkg::KIND_NONE)};
	end

	// advance string state on each accepted beat, clear after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cont_q      <= '0;
			seq_start_q <= '0;
			kind_q      <= puv_pkg::KIND_NONE;
			epos_q      <= '0;
			tent_q      <= 1'b0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				idx_q       <= '0;
				cont_q      <= '0;
				seq_start_q <= '0;
				kind_q      <= puv_pkg::KIND_NONE;
				epos_q      <= '0;
				tent_q      <= 1'b0;
			end else begin
				idx_q       <= idx_d;
				cont_q      <= cont_d;
				seq_start_q <= seq_start_d;
				kind_q      <= kind_d;
				epos_q      <= epos_d;
				tent_q      <= tent_d;
			end
		end
	end

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && s_axis_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_axis_tlast) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(puv_pkg::M_DATA_W - puv_pkg::RESULT_W){1'b0}}, res_q};

`ifndef NO_ASSERTIONS
	// state is clean after the last byte of a string
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tlast |=> idx_q == 8'd0 && cont_q == 2'd0
			&& kind_q == puv_pkg::KIND_NONE && !tent_q)
		else $error("string state not cleared after last beat");

	// a tentative error is always a bad continuation inside an open sequence
	a_tentative: assert property (@(posedge clk) disable iff (!arst_n)
		tent_q |-> kind_q == puv_pkg::KIND_BAD_CONT && cont_q != 2'd0)
		else $error("tentative error outside a sequence");

	// byte position never passes its saturation point
	a_idx_sat: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= POS_MAX)
		else $error("byte index beyond saturation");

	// a valid result carries no error kind and no position
	a_valid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[11:1] == 11'd0)
		else $error("valid result carries an error");
`endif

endmodule
